/* hdl/ast_pkg.sv */
// Shared widths, constants, register map and controller/datapath link types.
package ast_pkg;

   localparam int AZ_W      = 19;  // signed target azimuth
   localparam int FOLD_W    = 19;  // folded azimuth, 0 .. 359999
   localparam int MDEG_W    = 19;  // step angle register
   localparam int MAXINC_W  = 20;  // increment limit register
   localparam int STEP_W    = 21;  // signed step count
   localparam int DATUM_W   = 22;  // signed datum
   localparam int DIST_W    = 21;  // distance from datum, divider dividend
   localparam int ERR_W     = MDEG_W;  // residual always below the step angle
   localparam int DIV_STEPS = DIST_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [AZ_W:0] FULL_TURN_MDEG = (AZ_W + 1)'(360000);

   // Register map, selected by word address
   localparam logic REG_MDEG_PER_STEP      = 1'b0;
   localparam logic REG_MAX_STEP_INCREMENT = 1'b1;

   localparam logic [MDEG_W-1:0]   MDEG_PER_STEP_RESET      = MDEG_W'(720);
   localparam logic [MAXINC_W-1:0] MAX_STEP_INCREMENT_RESET = MAXINC_W'(250);

   typedef struct packed {
      logic capture;   // latch the accepted request
      logic setup;     // pick direction, move datum
      logic load_div;  // load divider with distance
      logic div_step;  // one restoring division step
      logic commit;    // update state and write the result register
   } cmd_type;

   typedef struct packed {
      logic halted;
      logic out_free;
   } status_type;

endpackage

/* hdl/ast_if.sv */
// Request and result channel interfaces.
interface ast_req_if
   import ast_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic signed [AZ_W-1:0] azimuth_mdeg;

   modport source (output valid, output azimuth_mdeg, input ready);
   modport sink   (input valid, input azimuth_mdeg, output ready);
endinterface

interface ast_rsp_if
   import ast_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic signed [STEP_W-1:0] step_count;
   logic                     rotate_cw;
   logic                     fault;

   modport source (output valid, output step_count, output rotate_cw, output fault,
                   input ready);
   modport sink   (input valid, input step_count, input rotate_cw, input fault,
                   output ready);
endinterface

/* hdl/ast_ctrl.sv */
// Sequencing state machine for the azimuth stepper tracker.
module ast_ctrl
   import ast_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SETUP  = 3'd1;
   localparam logic [2:0] ST_LOAD   = 3'd2;
   localparam logic [2:0] ST_DIV    = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_SETUP;
            end
         end
         ST_SETUP: begin
            // a halted block skips the work and reports the fault
            if (status.halted) begin
               state_in = ST_FINISH;
            end else begin
               cmd.setup = 1'b1;
               state_in  = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load_div = 1'b1;
            count_in     = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            count_in     = count_ff + CNT_W'(1);
            if (count_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the result register can take the request's result
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

endmodule

/* hdl/ast_dpath.sv */
// Tracking state, shared restoring divider and result register.
module ast_dpath
   import ast_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output status_type               status,
   input  logic signed [AZ_W-1:0]   azimuth_mdeg,
   input  logic [MDEG_W-1:0]        mdeg_per_step,
   input  logic [MAXINC_W-1:0]      max_step_increment,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [STEP_W-1:0] rsp_step_count,
   output logic                     rsp_rotate_cw,
   output logic                     rsp_fault
);

   // control state
   logic started_ff, started_in;
   logic halted_ff, halted_in;
   logic rsp_valid_ff, rsp_valid_in;

   // tracking state
   logic                      prev_neg_ff, prev_neg_in;
   logic [FOLD_W-1:0]         prev_fold_ff, prev_fold_in;
   logic signed [DATUM_W-1:0] datum_ff, datum_in;
   logic [DIST_W-1:0]         step_total_ff, step_total_in;
   logic [ERR_W-1:0]          err_ff, err_in;
   logic                      last_cw_ff, last_cw_in;

   // working registers
   logic signed [AZ_W-1:0]    az_ff, az_in;
   logic                      dir_cw_ff, dir_cw_in;
   logic [ERR_W-1:0]          rem_ff, rem_in;
   logic [DIST_W-1:0]         quo_ff, quo_in;

   // result register
   logic signed [STEP_W-1:0]  out_step_ff, out_step_in;
   logic                      out_cw_ff, out_cw_in;
   logic                      out_fault_ff, out_fault_in;

   logic                      az_neg;
   logic [AZ_W:0]             fold_wide;
   logic [FOLD_W-1:0]         fold;
   logic                      crossing, cw_now, reversal;
   logic signed [DATUM_W-1:0] pc, pe, full, datum_setup;
   logic signed [DATUM_W-1:0] dist_signed;
   logic [DIST_W-1:0]         dist_abs, dividend;
   logic [MDEG_W-1:0]         unit;
   logic [MDEG_W:0]           shifted, trial;
   logic                      ge;
   logic signed [DATUM_W-1:0] steps_wide, limit;
   logic signed [STEP_W-1:0]  steps_sat;
   logic                      over;

   assign status.halted   = halted_ff;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign unit = (mdeg_per_step == '0) ? MDEG_W'(1) : mdeg_per_step;

   // fold to 0 .. 360 degrees
   assign az_neg    = az_ff[AZ_W-1];
   assign fold_wide = {az_ff[AZ_W-1], az_ff} + FULL_TURN_MDEG;
   assign fold      = az_neg ? fold_wide[FOLD_W-1:0] : az_ff[FOLD_W-1:0];

   // north crossing: the fold offset changed between two targets
   assign crossing = started_ff && (az_neg != prev_neg_ff);
   assign cw_now   = !started_ff ? 1'b1 :
                     crossing    ? !(fold > prev_fold_ff) : (fold >= prev_fold_ff);
   assign reversal = started_ff && (last_cw_ff != cw_now);

   assign pc   = DATUM_W'(prev_fold_ff);
   assign pe   = DATUM_W'(err_ff);
   assign full = DATUM_W'(FULL_TURN_MDEG);

   always_comb begin
      priority if (reversal) begin
         datum_setup = cw_now ? (pc - pe) : (pc + pe);
      end else if (crossing) begin
         datum_setup = cw_now ? (pc - full - pe) : (pc + full + pe);
      end else begin
         datum_setup = datum_ff;
      end
   end

   assign dist_signed = DATUM_W'(fold) - datum_ff;
   assign dist_abs    = dist_signed[DATUM_W-1] ? DIST_W'(-dist_signed)
                                               : dist_signed[DIST_W-1:0];
   assign dividend    = started_ff ? dist_abs : DIST_W'(fold);

   // restoring division step
   assign shifted = {rem_ff, quo_ff[DIST_W-1]};
   assign ge      = shifted >= {1'b0, unit};
   assign trial   = shifted - {1'b0, unit};

   // increment against the running total; the first request counts from north
   assign steps_wide = DATUM_W'(quo_ff) - (started_ff ? DATUM_W'(step_total_ff) : '0);
   assign limit      = DATUM_W'(max_step_increment);
   assign over       = started_ff && (steps_wide > limit);
   assign steps_sat  = (steps_wide[DATUM_W-1] != steps_wide[STEP_W-1]) ?
                       (steps_wide[DATUM_W-1] ? {1'b1, {(STEP_W-1){1'b0}}}
                                              : {1'b0, {(STEP_W-1){1'b1}}})
                       : steps_wide[STEP_W-1:0];

   always_comb begin
      started_in    = started_ff;
      halted_in     = halted_ff;
      prev_neg_in   = prev_neg_ff;
      prev_fold_in  = prev_fold_ff;
      datum_in      = datum_ff;
      step_total_in = step_total_ff;
      err_in        = err_ff;
      last_cw_in    = last_cw_ff;
      az_in         = az_ff;
      dir_cw_in     = dir_cw_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      out_step_in   = out_step_ff;
      out_cw_in     = out_cw_ff;
      out_fault_in  = out_fault_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      if (cmd.capture) begin
         az_in = azimuth_mdeg;
      end
      if (cmd.setup) begin
         dir_cw_in = cw_now;
         datum_in  = datum_setup;
         if (crossing || reversal) begin
            step_total_in = '0;
         end
      end
      if (cmd.load_div) begin
         rem_in = '0;
         quo_in = dividend;
      end
      if (cmd.div_step) begin
         rem_in = ge ? trial[ERR_W-1:0] : shifted[ERR_W-1:0];
         quo_in = {quo_ff[DIST_W-2:0], ge};
      end
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         if (halted_ff) begin
            out_step_in  = '0;
            out_cw_in    = 1'b0;
            out_fault_in = 1'b1;
         end else begin
            out_step_in  = steps_sat;
            out_cw_in    = dir_cw_ff;
            out_fault_in = over;
            halted_in    = over;
            prev_neg_in  = az_neg;
            prev_fold_in = fold;
            last_cw_in   = dir_cw_ff;
            if (started_ff) begin
               step_total_in = quo_ff;
               err_in        = rem_ff;
            end else begin
               // datum lands on the last whole step below the target
               datum_in   = DATUM_W'(fold) - DATUM_W'(rem_ff);
               started_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff    <= 1'b0;
         halted_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         prev_neg_ff   <= 1'b0;
         prev_fold_ff  <= '0;
         datum_ff      <= '0;
         step_total_ff <= '0;
         err_ff        <= '0;
         last_cw_ff    <= 1'b0;
      end else begin
         started_ff    <= started_in;
         halted_ff     <= halted_in;
         rsp_valid_ff  <= rsp_valid_in;
         prev_neg_ff   <= prev_neg_in;
         prev_fold_ff  <= prev_fold_in;
         datum_ff      <= datum_in;
         step_total_ff <= step_total_in;
         err_ff        <= err_in;
         last_cw_ff    <= last_cw_in;
      end
   end

   always_ff @(posedge clock) begin
      az_ff        <= az_in;
      dir_cw_ff    <= dir_cw_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      out_step_ff  <= out_step_in;
      out_cw_ff    <= out_cw_in;
      out_fault_ff <= out_fault_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_step_count = out_step_ff;
   assign rsp_rotate_cw  = out_cw_ff;
   assign rsp_fault      = out_fault_ff;

endmodule

/* hdl/azimuth_stepper_tracker_top.sv */
// Top level of the azimuth stepper tracker: register port, controller and datapath.
//
//   channel   direction  handshake          payload
//   req_chan  in         valid/ready        azimuth_mdeg
//   rsp_chan  out        valid/ready        step_count, rotate_cw, fault
//   APB       in         psel/penable/...   mdeg_per_step @0x0, max_step_increment @0x4
//
// After acceptance a request passes through setup, divider load, 21 iterations of the
// shared restoring divider, and the finishing state before the next acceptance.
// Once halted, a request goes from setup straight to the finishing state.
// Reset is synchronous and clears the tracking state and both registers to defaults.
// A result waits in the output register while the next request is taken; the finishing
// cycle stalls only when that register is still full.
module azimuth_stepper_tracker_top
   import ast_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   ast_req_if.sink               req_chan,
   ast_rsp_if.source             rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [MDEG_W-1:0]   mdeg_per_step_ff, mdeg_per_step_in;
   logic [MAXINC_W-1:0] max_step_increment_ff, max_step_increment_in;
   logic                csr_write;
   cmd_type             cmd;
   status_type          status;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      mdeg_per_step_in      = mdeg_per_step_ff;
      max_step_increment_in = max_step_increment_ff;
      if (csr_write) begin
         unique case (paddr[2])
            REG_MDEG_PER_STEP:      mdeg_per_step_in      = pwdata[MDEG_W-1:0];
            REG_MAX_STEP_INCREMENT: max_step_increment_in = pwdata[MAXINC_W-1:0];
            default:                mdeg_per_step_in      = mdeg_per_step_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_MDEG_PER_STEP:      prdata = CSR_DATA_W'(mdeg_per_step_ff);
         REG_MAX_STEP_INCREMENT: prdata = CSR_DATA_W'(max_step_increment_ff);
         default:                prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mdeg_per_step_ff      <= MDEG_PER_STEP_RESET;
         max_step_increment_ff <= MAX_STEP_INCREMENT_RESET;
      end else begin
         mdeg_per_step_ff      <= mdeg_per_step_in;
         max_step_increment_ff <= max_step_increment_in;
      end
   end

   ast_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ast_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .azimuth_mdeg       (req_chan.azimuth_mdeg),
      .mdeg_per_step      (mdeg_per_step_ff),
      .max_step_increment (max_step_increment_ff),
      .rsp_valid          (rsp_chan.valid),
      .rsp_ready          (rsp_chan.ready),
      .rsp_step_count     (rsp_chan.step_count),
      .rsp_rotate_cw      (rsp_chan.rotate_cw),
      .rsp_fault          (rsp_chan.fault)
   );

endmodule
